// File: src/fsla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsla_pkg;

  localparam int MAX_OBJECTS_DEFAULT = 256;

  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int BYTES_W  = 17;
  localparam int HDR_W    = 7;
  localparam int OFFSET_W = 25;
  localparam int SIZE_W   = BYTES_W + 1;
  localparam int CFG_IDX_W = 2;

  // link store never holds more than this many entries, indices are 8 bits
  localparam int INDEX_SPAN = 1 << INDEX_W;

  localparam logic [COUNT_W-1:0] HEAD_NONE = COUNT_W'(INDEX_SPAN);
  localparam logic [SIZE_W-1:0]  ALIGN_MASK = SIZE_W'(15);

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_REBUILD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_OFFSET = 2'd2;

  localparam logic [BYTES_W-1:0] OBJECT_BYTES_RESET  = BYTES_W'(16);
  localparam logic [COUNT_W-1:0] OBJECT_COUNT_RESET  = COUNT_W'(256);
  localparam logic [HDR_W-1:0]   HEADER_OFFSET_RESET = '0;

  typedef struct packed {
    logic [1:0]         action;
    logic [INDEX_W-1:0] free_index;
  } in_word_t;

  typedef struct packed {
    logic                status;
    logic [INDEX_W-1:0]  obj_index;
    logic [OFFSET_W-1:0] obj_offset;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic mul;
    logic fin;
  } ctl_cmd_t;

endpackage

`default_nettype wire

// File: src/fsla_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fsla_ctrl
  import fsla_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  output logic      done,
  output ctl_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FIN);
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin    = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// File: src/fsla_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module fsla_datapath
  import fsla_pkg::*;
#(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ctl_cmd_t             cmd,
  input  wire in_word_t             request,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTES_W-1:0]   cfg_data,
  output out_word_t                 result
);

  localparam int DEPTH  = (MAX_OBJECTS < INDEX_SPAN) ? MAX_OBJECTS : INDEX_SPAN;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(DEPTH);

  // index modulo MAX_OBJECTS, worked out at elaboration
  logic [SLOT_W-1:0] slot_tab [INDEX_SPAN];
  for (genvar i = 0; i < INDEX_SPAN; i++) begin : g_slot
    assign slot_tab[i] = SLOT_W'(i % MAX_OBJECTS);
  end

  logic [BYTES_W-1:0] object_bytes;
  logic [COUNT_W-1:0] object_count;
  logic [HDR_W-1:0]   header_offset;

  logic [COUNT_W-1:0] head;
  logic [COUNT_W-1:0] untouched;

  logic [1:0]         act;
  logic [INDEX_W-1:0] fidx;

  logic [INDEX_W-1:0] link_mem [DEPTH];
  logic [INDEX_W-1:0] link_rd;

  logic               res_status;
  logic               res_live;
  logic [INDEX_W-1:0] res_idx;
  logic [OFFSET_W-1:0] prod;

  logic [COUNT_W-1:0] eff_count;
  logic [SIZE_W-1:0]  size;
  logic               head_valid;
  logic               wr_en;
  logic [INDEX_W-1:0] wr_data;
  logic [COUNT_W-1:0] fresh_diff;

  assign eff_count  = (object_count > CAP) ? CAP : object_count;
  assign size       = ({1'b0, object_bytes} + ALIGN_MASK) & ~ALIGN_MASK;
  assign head_valid = (head != HEAD_NONE);
  assign wr_en      = cmd.exec && (act == ACT_FREE);
  assign wr_data    = head_valid ? head[INDEX_W-1:0] : fidx;
  assign fresh_diff = eff_count - untouched;

  always_ff @(posedge clk) begin
    if (rst) begin
      object_bytes  <= OBJECT_BYTES_RESET;
      object_count  <= OBJECT_COUNT_RESET;
      header_offset <= HEADER_OFFSET_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OBJECT_BYTES:  object_bytes  <= cfg_data;
        REG_OBJECT_COUNT:  object_count  <= cfg_data[COUNT_W-1:0];
        REG_HEADER_OFFSET: header_offset <= cfg_data[HDR_W-1:0];
        default: ;
      endcase
    end
  end

  // link store, read at the head every cycle so the link is ready on exec
  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[slot_tab[fidx]] <= wr_data;
    end
    link_rd <= link_mem[slot_tab[head[INDEX_W-1:0]]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= request.action;
      fidx <= request.free_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= HEAD_NONE;
      untouched <= CAP;
    end else if (cmd.exec) begin
      case (act)
        ACT_ALLOC: begin
          if (head_valid) begin
            // a link pointing at itself ends the pushed chain
            head <= (link_rd == head[INDEX_W-1:0]) ? HEAD_NONE : {1'b0, link_rd};
          end else if (untouched != '0) begin
            untouched <= untouched - 1'b1;
          end
        end
        ACT_FREE:    head <= {1'b0, fidx};
        ACT_REBUILD: begin
          head      <= HEAD_NONE;
          untouched <= eff_count;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= 1'b0;
      res_live   <= 1'b0;
      res_idx    <= '0;
      if (act == ACT_ALLOC) begin
        if (head_valid) begin
          res_live <= 1'b1;
          res_idx  <= head[INDEX_W-1:0];
        end else if (untouched != '0) begin
          res_live <= 1'b1;
          // count lowered since rebuild: hand out object zero
          res_idx  <= (eff_count >= untouched) ? fresh_diff[INDEX_W-1:0] : '0;
        end else begin
          res_status <= 1'b1;
        end
      end
    end
    if (cmd.mul) begin
      prod <= OFFSET_W'(res_idx) * OFFSET_W'(size);
    end
    if (cmd.fin) begin
      result.status     <= res_status;
      result.obj_index  <= res_idx;
      result.obj_offset <= res_live ? (prod + OFFSET_W'(header_offset)) : '0;
    end
  end

endmodule

`default_nettype wire

// File: src/fixed_size_free_list_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// LIFO free-list allocator for equal-sized objects. A request word is taken
// when start is high and busy is low; done is then high for exactly one cycle
// with its result word on result, and cannot be held off by the receiver.
// Each request passes through link update, index times size multiply and
// header add before the result is shown, and busy keeps a new request out
// until then; a new request may be started in the cycle that the previous
// result is shown. Configuration writes are always ready and take effect at once;
// write them only while the block is idle.
module fixed_size_free_list_allocator
  import fsla_pkg::*;
#(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_word_t             request,
  output logic                      done,
  output out_word_t                 result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTES_W-1:0]   cfg_data
);

  ctl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  fsla_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  fsla_datapath #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .request   (request),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fsla_pkg::*;

  localparam int MAX_OBJ = MAX_OBJECTS_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_word_t request = '0;
  logic done;
  out_word_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTES_W-1:0] cfg_data = '0;

  fixed_size_free_list_allocator #(
    .MAX_OBJECTS(MAX_OBJ)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // allocator shadow state
  logic [INDEX_W-1:0] link_mem [MAX_OBJ];
  logic [COUNT_W-1:0] head_ptr = HEAD_NONE;
  logic [COUNT_W-1:0] fresh_left = COUNT_W'(256);
  logic [BYTES_W-1:0] size_cfg = OBJECT_BYTES_RESET;
  logic [COUNT_W-1:0] count_cfg = OBJECT_COUNT_RESET;
  logic [HDR_W-1:0] hdr_cfg = HEADER_OFFSET_RESET;

  in_word_t request_queue [$];
  out_word_t expected_words [$];
  out_word_t want_word;

  int items_pushed = 0;
  int words_accepted = 0;
  int results_seen = 0;
  int errs = 0;
  int cycle_count = 0;
  bit word_taken = 0;
  bit cfg_taken = 0;
  bit idle_enable = 1;

  function automatic logic [COUNT_W-1:0] live_count();
    logic [COUNT_W-1:0] c;
    c = count_cfg;
    if (c > MAX_OBJ) c = COUNT_W'(MAX_OBJ);
    if (c > 256) c = COUNT_W'(256);
    return c;
  endfunction

  function automatic out_word_t alloc_predict(in_word_t w);
    out_word_t o;
    logic [INDEX_W-1:0] h;
    logic [INDEX_W-1:0] nxt;
    logic [COUNT_W-1:0] c;
    logic [SIZE_W-1:0] sz;
    logic [31:0] full;
    o = '0;
    case (w.action)
      ACT_ALLOC: begin
        if (head_ptr != HEAD_NONE) begin
          h = head_ptr[INDEX_W-1:0];
          nxt = link_mem[h];
          o.obj_index = h;
          head_ptr = (nxt == h) ? HEAD_NONE : {1'b0, nxt};
        end else if (fresh_left != 0) begin
          c = live_count();
          o.obj_index = (c >= fresh_left) ? INDEX_W'(c - fresh_left) : '0;
          fresh_left = fresh_left - 1'b1;
        end else begin
          o.status = 1'b1;
        end
        if (!o.status) begin
          sz = ({1'b0, size_cfg} + ALIGN_MASK) & ~ALIGN_MASK;
          full = 32'(o.obj_index) * 32'(sz) + 32'(hdr_cfg);
          o.obj_offset = full[OFFSET_W-1:0];
        end
      end
      ACT_FREE: begin
        link_mem[w.free_index] = (head_ptr == HEAD_NONE) ? w.free_index
                                                         : head_ptr[INDEX_W-1:0];
        head_ptr = {1'b0, w.free_index};
      end
      ACT_REBUILD: begin
        head_ptr = HEAD_NONE;
        fresh_left = live_count();
      end
      default: ;
    endcase
    return o;
  endfunction

  // driver: one request word per handshake
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      word_taken = 0;
      if (request_queue.size() != 0 && !(idle_enable && $urandom_range(99) < 31)) begin
        request <= request_queue.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          $error("unexpected result word: status %0d index %0d offset %0d",
                 result.status, result.obj_index, result.obj_offset);
          errs++;
        end else begin
          want_word = expected_words.pop_front();
          if (result.status !== want_word.status) begin
            $error("status mismatch: expected %0d, got %0d", want_word.status, result.status);
            errs++;
          end
          if (result.obj_index !== want_word.obj_index) begin
            $error("obj_index mismatch: expected %0d, got %0d",
                   want_word.obj_index, result.obj_index);
            errs++;
          end
          if (result.obj_offset !== want_word.obj_offset) begin
            $error("obj_offset mismatch: expected %0d, got %0d",
                   want_word.obj_offset, result.obj_offset);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        expected_words.push_back(alloc_predict(request));
        words_accepted++;
        word_taken = 1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OBJECT_BYTES:  size_cfg = cfg_data;
          REG_OBJECT_COUNT:  count_cfg = cfg_data[COUNT_W-1:0];
          REG_HEADER_OFFSET: hdr_cfg = cfg_data[HDR_W-1:0];
          default: ;
        endcase
        cfg_taken = 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_item(logic [1:0] act, logic [INDEX_W-1:0] idx);
    in_word_t w;
    w.action = act;
    w.free_index = idx;
    request_queue.push_back(w);
    items_pushed++;
  endtask

  // hold off until every issued word has produced its result
  task automatic settle();
    while (results_seen != items_pushed) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTES_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    cfg_taken = 0;
    do @(negedge clk); while (!cfg_taken);
    cfg_taken = 0;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_traffic(int n, int cnt);
    int made;
    int r;
    int len;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      if (r < 45) begin
        len = $urandom_range(1, (cnt < 12) ? cnt + 3 : 10);
        repeat (len) push_item(ACT_ALLOC, INDEX_W'($urandom_range(255)));
        made += len;
      end else if (r < 80) begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          if (cnt > 0 && $urandom_range(9) < 8)
            push_item(ACT_FREE, INDEX_W'($urandom_range(cnt - 1)));
          else
            push_item(ACT_FREE, INDEX_W'($urandom_range(255)));
        end
        made += len;
      end else if (r < 85) begin
        push_item(ACT_REBUILD, INDEX_W'($urandom_range(255)));
        made++;
      end else if (r < 90) begin
        push_item(ACT_IGNORED, INDEX_W'($urandom_range(255)));
      end else begin
        push_item(2'($urandom_range(2)), INDEX_W'($urandom_range(255)));
        made++;
      end
    end
  endtask

  task automatic run_phase(logic [BYTES_W-1:0] bytes_data, logic [BYTES_W-1:0] count_data,
                           logic [BYTES_W-1:0] hdr_data, bit rebuild, bit idle,
                           int n, int drain);
    int eff;
    settle();
    write_reg(REG_OBJECT_BYTES, bytes_data);
    write_reg(REG_OBJECT_COUNT, count_data);
    write_reg(REG_HEADER_OFFSET, hdr_data);
    eff = int'(count_data[COUNT_W-1:0]);
    if (eff > MAX_OBJ) eff = MAX_OBJ;
    if (eff > 256) eff = 256;
    @(posedge clk);
    idle_enable = idle;
    if (rebuild) push_item(ACT_REBUILD, '0);
    repeat (drain) push_item(ACT_ALLOC, INDEX_W'($urandom_range(255)));
    random_traffic(n, eff);
  endtask

  initial begin
    int guard;
    logic [COUNT_W-1:0] rc;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at reset settings
    push_item(ACT_ALLOC, 8'h00);
    push_item(ACT_ALLOC, 8'hFF);
    push_item(ACT_ALLOC, 8'h00);
    push_item(ACT_FREE, 8'hFF);
    push_item(ACT_ALLOC, 8'h00);
    push_item(ACT_FREE, 8'h00);
    // freeing the head again closes the chain on itself
    push_item(ACT_FREE, 8'h00);
    push_item(ACT_ALLOC, 8'hFF);
    push_item(ACT_ALLOC, 8'hFF);
    push_item(ACT_ALLOC, 8'h00);
    push_item(ACT_FREE, 8'hAA);
    push_item(ACT_FREE, 8'h55);
    push_item(ACT_ALLOC, 8'h00);
    push_item(ACT_ALLOC, 8'h00);
    push_item(ACT_IGNORED, 8'hFF);
    push_item(ACT_IGNORED, 8'h00);
    push_item(ACT_REBUILD, 8'hFF);
    push_item(ACT_ALLOC, 8'h00);
    push_item(ACT_FREE, 8'h5A);
    push_item(ACT_REBUILD, 8'h00);
    push_item(ACT_ALLOC, 8'h00);
    push_item(ACT_ALLOC, 8'h00);

    // count shrunk under a live list, no rebuild
    run_phase(17'd65536, 17'd1, 17'd64, 0, 1, 180, 0);
    // empty slab, allocs fail until something is freed
    run_phase(17'd0, 17'd0, 17'd127, 1, 1, 150, 0);
    // oversized count and size, full drain with no idling
    run_phase(17'h1FFFF, 17'd511, 17'd1, 1, 0, 200, 260);
    run_phase(17'd1, 17'd2, 17'd0, 1, 1, 200, 0);
    run_phase(17'd17, 17'd300, 17'd63, 0, 1, 150, 0);
    run_phase(17'd16, 17'd256, 17'd0, 1, 1, 120, 0);
    for (int p = 0; p < 6; p++) begin
      rc = ($urandom_range(3) == 0) ? COUNT_W'($urandom_range(1, 256))
                                    : COUNT_W'($urandom_range(1, 12));
      run_phase(($urandom_range(3) == 0) ? BYTES_W'($urandom_range(17'h1FFFF))
                                         : BYTES_W'($urandom_range(1, 64) * 16),
                {8'($urandom_range(255)), rc},
                {10'($urandom_range(1023)), 7'($urandom_range(127))},
                $urandom_range(3) != 0, 1, 120, 0);
    end

    while (request_queue.size() != 0 || words_accepted != items_pushed) @(negedge clk);
    guard = 0;
    while (expected_words.size() != 0 && guard < 200) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected result words never arrived", expected_words.size());
      errs++;
    end
    if (errs == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
